// ===== rtl/lzd_pkg.sv =====
package lzd_pkg;

  // Field widths of the compressed and decompressed streams.
  localparam int BYTE_W = 8;
  localparam int DIST_W = 12;
  localparam int CNT_W = 5;
  localparam int REM_W = 24;

  // Configuration port geometry.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Register index codes, taken from the word address bit.
  localparam logic REG_OUTPUT_LENGTH = 1'b0;

  // A match length field of n copies n plus this many bytes.
  localparam logic [CNT_W-1:0] LEN_BIAS = 5'd3;

  // A flag byte covers this many tokens.
  localparam logic [3:0] FLAG_COUNT = 4'd8;

  // One unit of work for the copy engine: a literal or a match copy.
  typedef struct packed {
    logic              is_match;
    logic [BYTE_W-1:0] lit;
    logic [CNT_W-1:0]  count;
    logic [DIST_W-1:0] offs;
    logic              done;
  } lzd_cmd_t;

endpackage

// ===== rtl/lzd_in_if.sv =====
interface lzd_in_if
  import lzd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              stream_start;

  modport source (output valid, output in_byte, output stream_start, input ready);
  modport sink (input valid, input in_byte, input stream_start, output ready);
endinterface

// ===== rtl/lzd_out_if.sv =====
interface lzd_out_if
  import lzd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              run_last;
  logic              stream_done;

  modport source (output valid, output out_byte, output run_last, output stream_done,
                  input ready);
  modport sink (input valid, input out_byte, input run_last, input stream_done,
                output ready);
endinterface

// ===== rtl/lzd_front.sv =====
module lzd_front
  import lzd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  lzd_in_if.sink            in_ch,
  input  logic [REM_W-1:0]  output_length,
  input  logic              clearing,
  input  logic              fifo_full,
  output logic              push,
  output lzd_cmd_t          cmd
);

  logic [BYTE_W-1:0] flag_r, flag_nxt;
  logic [3:0]        left_r, left_nxt;
  logic              phase_r, phase_nxt;
  logic [BYTE_W-1:0] hi_r, hi_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;

  logic [BYTE_W-1:0] flag_e;
  logic [3:0]        left_e;
  logic              phase_e;
  logic [BYTE_W-1:0] hi_e;
  logic [REM_W-1:0]  rem_e;
  logic [CNT_W-1:0]  len;
  logic [CNT_W-1:0]  n;
  logic              push_c;
  logic              accept;

  // Every beat may produce a command, so a beat is taken only with queue space.
  assign in_ch.ready = !fifo_full && !clearing;
  assign accept = in_ch.valid && in_ch.ready;
  assign push = accept && push_c;

  // Parser: a stream start clears the token state first, then the beat is parsed.
  always_comb begin
    flag_e  = in_ch.stream_start ? '0 : flag_r;
    left_e  = in_ch.stream_start ? '0 : left_r;
    phase_e = in_ch.stream_start ? 1'b0 : phase_r;
    hi_e    = in_ch.stream_start ? '0 : hi_r;
    rem_e   = in_ch.stream_start ? output_length : rem_r;

    flag_nxt  = flag_e;
    left_nxt  = left_e;
    phase_nxt = phase_e;
    hi_nxt    = hi_e;
    rem_nxt   = rem_e;

    len = {1'b0, hi_e[BYTE_W-1:4]} + LEN_BIAS;
    n   = (rem_e < {{(REM_W-CNT_W){1'b0}}, len}) ? rem_e[CNT_W-1:0] : len;

    push_c       = 1'b0;
    cmd.is_match = 1'b0;
    cmd.lit      = in_ch.in_byte;
    cmd.count    = {{(CNT_W-1){1'b0}}, 1'b1};
    cmd.offs     = {hi_e[3:0], in_ch.in_byte};
    cmd.done     = 1'b0;

    if (rem_e != '0) begin
      if (phase_e) begin
        // Second byte of a match token: the copy may be cut short by the end.
        push_c       = 1'b1;
        cmd.is_match = 1'b1;
        cmd.count    = n;
        rem_nxt      = rem_e - {{(REM_W-CNT_W){1'b0}}, n};
        cmd.done     = (rem_nxt == '0);
        phase_nxt    = 1'b0;
        flag_nxt     = {flag_e[BYTE_W-2:0], 1'b0};
        left_nxt     = left_e - 4'd1;
      end else if (left_e == '0) begin
        flag_nxt = in_ch.in_byte;
        left_nxt = FLAG_COUNT;
      end else if (flag_e[BYTE_W-1]) begin
        hi_nxt    = in_ch.in_byte;
        phase_nxt = 1'b1;
      end else begin
        push_c   = 1'b1;
        rem_nxt  = rem_e - {{(REM_W-1){1'b0}}, 1'b1};
        cmd.done = (rem_nxt == '0);
        flag_nxt = {flag_e[BYTE_W-2:0], 1'b0};
        left_nxt = left_e - 4'd1;
      end
    end
  end

  // Parser state advances on each accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r  <= '0;
      left_r  <= '0;
      phase_r <= 1'b0;
      hi_r    <= '0;
      rem_r   <= '0;
    end else if (accept) begin
      flag_r  <= flag_nxt;
      left_r  <= left_nxt;
      phase_r <= phase_nxt;
      hi_r    <= hi_nxt;
      rem_r   <= rem_nxt;
    end
  end

endmodule

// ===== rtl/lzd_cmd_fifo.sv =====
module lzd_cmd_fifo
  import lzd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  lzd_cmd_t push_cmd,
  input  logic     pop,
  output lzd_cmd_t head_cmd,
  output logic     full,
  output logic     empty
);

  localparam int DEPTH = 4;
  localparam int PW = $clog2(DEPTH);

  lzd_cmd_t        slot_r [DEPTH];
  logic [PW-1:0]   wr_r;
  logic [PW-1:0]   rd_r;
  logic [PW:0]     cnt_r;

  assign full = (cnt_r == (PW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head_cmd = slot_r[rd_r];

  // Small circular queue of commands between parser and copy engine.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        slot_r[wr_r] <= push_cmd;
        wr_r         <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/lzd_back.sv =====
module lzd_back
  import lzd_pkg::*;
#(
  parameter int WINDOW_DEPTH = 4096
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     fifo_empty,
  input  lzd_cmd_t cmd,
  output logic     pop,
  output logic     clearing,
  lzd_out_if.source out_ch
);

  localparam int AW = $clog2(WINDOW_DEPTH);

  typedef enum logic {B_CLEAR, B_RUN} bstate_t;

  bstate_t           state_r;
  logic [AW-1:0]     clr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [AW-1:0]     rd_r;
  logic [AW-1:0]     ip_r;
  logic              match_r;
  logic [BYTE_W-1:0] lit_r;
  logic              done_r;

  logic              p1_valid_r;
  logic              p1_match_r;
  logic [BYTE_W-1:0] p1_lit_r;
  logic              p1_last_r;
  logic              p1_done_r;
  logic [AW-1:0]     p1_wa_r;
  logic [BYTE_W-1:0] rdata_r;

  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_last_r;
  logic              out_done_r;

  logic [BYTE_W-1:0] mem [WINDOW_DEPTH];

  logic              go;
  logic              running;
  logic              load;
  logic              issue;
  logic              emit;
  logic [BYTE_W-1:0] emit_byte;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [BYTE_W-1:0] mem_wd;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.run_last    = out_last_r;
  assign out_ch.stream_done = out_done_r;

  // Pipeline control: read stage, then write-back and output register.
  always_comb begin
    clearing  = (state_r == B_CLEAR);
    running   = (state_r == B_RUN);
    go        = !out_valid_r || out_ch.ready;
    load      = running && (cnt_r == '0) && !fifo_empty;
    pop       = load;
    issue     = running && go && (cnt_r != '0);
    emit      = running && go && p1_valid_r;
    emit_byte = p1_match_r ? rdata_r : p1_lit_r;
    mem_we    = clearing || emit;
    mem_wa    = clearing ? clr_r : p1_wa_r;
    mem_wd    = clearing ? '0 : emit_byte;
  end

  // History window; a read of the address written in the same cycle is forwarded.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (issue) begin
      rdata_r <= (emit && (p1_wa_r == rd_r)) ? emit_byte : mem[rd_r];
    end
  end

  // Sequencer: clearing pass, command load, byte issue and output.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      clr_r       <= '0;
      cnt_r       <= '0;
      ip_r        <= '0;
      p1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        B_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (&clr_r) begin
            state_r <= B_RUN;
          end
        end
        B_RUN: begin
          if (load) begin
            cnt_r   <= cmd.count;
            match_r <= cmd.is_match;
            lit_r   <= cmd.lit;
            done_r  <= cmd.done;
            rd_r    <= ip_r - AW'(cmd.offs) - 1'b1;
          end else if (issue) begin
            cnt_r      <= cnt_r - 1'b1;
            rd_r       <= rd_r + 1'b1;
            ip_r       <= ip_r + 1'b1;
            p1_match_r <= match_r;
            p1_lit_r   <= lit_r;
            p1_last_r  <= (cnt_r == {{(CNT_W-1){1'b0}}, 1'b1});
            p1_done_r  <= done_r && (cnt_r == {{(CNT_W-1){1'b0}}, 1'b1});
            p1_wa_r    <= ip_r;
          end
          if (go) begin
            p1_valid_r  <= issue;
            out_valid_r <= emit;
          end
          if (emit) begin
            out_byte_r <= emit_byte;
            out_last_r <= p1_last_r;
            out_done_r <= p1_done_r;
          end
        end
        default: begin
          state_r <= B_CLEAR;
        end
      endcase
    end
  end

endmodule

// ===== rtl/lz77_stream_decompressor_unit.sv =====
// LZ77 stream decompressor: takes the compressed bytes that follow the
// header one beat at a time and produces the decompressed bytes, one per
// output beat, until output_length bytes are out. A parser accepts up to
// one beat per cycle while the command queue has room; the copy engine
// loads each literal or match command from the queue and then issues its
// bytes, the limit being the single read port of the window memory, which
// yields one byte per cycle while the output is not stalled. After reset the
// block zeroes the history window and accepts no beat meanwhile;
// configuration writes are taken throughout.
module lz77_stream_decompressor_unit
  import lzd_pkg::*;
#(
  parameter int WINDOW_DEPTH = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  lzd_in_if.sink                in_ch,
  lzd_out_if.source             out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic [REM_W-1:0] output_length_r;
  logic             cfg_wr;
  logic             clearing;
  logic             fifo_full;
  logic             fifo_empty;
  logic             push;
  logic             pop;
  lzd_cmd_t         push_cmd;
  lzd_cmd_t         head_cmd;

  // Register file: a single length register.
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite &&
                  (cfg_paddr[2] == REG_OUTPUT_LENGTH);
  assign cfg_prdata = (cfg_paddr[2] == REG_OUTPUT_LENGTH) ?
                      {{(CFG_DATA_W-REM_W){1'b0}}, output_length_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      output_length_r <= '0;
    end else if (cfg_wr) begin
      output_length_r <= cfg_pwdata[REM_W-1:0];
    end
  end

  lzd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .output_length (output_length_r),
    .clearing      (clearing),
    .fifo_full     (fifo_full),
    .push          (push),
    .cmd           (push_cmd)
  );

  lzd_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .full     (fifo_full),
    .empty    (fifo_empty)
  );

  lzd_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_empty (fifo_empty),
    .cmd        (head_cmd),
    .pop        (pop),
    .clearing   (clearing),
    .out_ch     (out_ch)
  );

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench
  import lzd_pkg::*;
();

  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 110;
  localparam int MAX_PRINTS = 100;
  localparam logic [CFG_ADDR_W-1:0] LEN_ADDR = {REG_OUTPUT_LENGTH, 2'b00};

  // One decompressed byte as the block should deliver it.
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              done;
  } decoded_t;

  // One row of directed stimulus, with the result typed in where chk is set.
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              start;
    logic              set_len;
    logic [REM_W-1:0]  len;
    logic              chk;
    logic [4:0]        n;
    logic [BYTE_W-1:0] last_byte;
    logic              done;
  } stim_row_t;

  localparam stim_row_t NO_CHECK = '0;

  logic clk;
  logic rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  lzd_in_if  in_ch ();
  lzd_out_if out_ch ();

  lz77_stream_decompressor_unit uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Decoder mirror: history window, parser and stream length.
  logic [BYTE_W-1:0] hist_mem [4096];
  logic [DIST_W-1:0] wr_ptr;
  logic [BYTE_W-1:0] flag_reg;
  logic [3:0]        flag_cnt;
  logic              await_low;
  logic [BYTE_W-1:0] hi_byte;
  logic [REM_W-1:0]  len_left;
  logic [REM_W-1:0]  len_cfg;

  decoded_t  expected_q [$];
  stim_row_t beat_checks [$];
  int        mismatches;
  int        used_items;
  int        cycle_count;
  bit        calm;

  // Directed rows: unstarted and zero-length streams, extreme distances and
  // lengths, a match cut short by the end of the stream, a restart mid-token.
  stim_row_t dir_rows [17] = '{
    '{8'hA5, 1'b0, 1'b1, 24'd0,  1'b1, 5'd0,  8'h00, 1'b0},
    '{8'h00, 1'b1, 1'b0, 24'd0,  1'b1, 5'd0,  8'h00, 1'b0},
    '{8'hFF, 1'b0, 1'b0, 24'd0,  1'b1, 5'd0,  8'h00, 1'b0},
    '{8'h7F, 1'b1, 1'b1, 24'd20, 1'b1, 5'd0,  8'h00, 1'b0},
    '{8'hFF, 1'b0, 1'b0, 24'd0,  1'b1, 5'd1,  8'hFF, 1'b0},
    '{8'h0F, 1'b0, 1'b0, 24'd0,  1'b1, 5'd0,  8'h00, 1'b0},
    '{8'hFF, 1'b0, 1'b0, 24'd0,  1'b1, 5'd3,  8'h00, 1'b0},
    '{8'h20, 1'b0, 1'b0, 24'd0,  1'b1, 5'd0,  8'h00, 1'b0},
    '{8'h03, 1'b0, 1'b0, 24'd0,  1'b1, 5'd5,  8'hFF, 1'b0},
    '{8'hF0, 1'b0, 1'b0, 24'd0,  1'b1, 5'd0,  8'h00, 1'b0},
    '{8'h00, 1'b0, 1'b0, 24'd0,  1'b1, 5'd11, 8'hFF, 1'b1},
    '{8'h3C, 1'b0, 1'b0, 24'd0,  1'b1, 5'd0,  8'h00, 1'b0},
    '{8'h80, 1'b1, 1'b0, 24'd0,  1'b1, 5'd0,  8'h00, 1'b0},
    '{8'h10, 1'b0, 1'b0, 24'd0,  1'b1, 5'd0,  8'h00, 1'b0},
    '{8'h00, 1'b1, 1'b0, 24'd0,  1'b1, 5'd0,  8'h00, 1'b0},
    '{8'h00, 1'b0, 1'b0, 24'd0,  1'b1, 5'd1,  8'h00, 1'b0},
    '{8'h5A, 1'b0, 1'b0, 24'd0,  1'b1, 5'd1,  8'h5A, 1'b0}
  };

  task automatic log_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Appends one byte to the window and queues it as an expected beat.
  task automatic put_history(input logic [BYTE_W-1:0] v, input logic end_of_run);
    hist_mem[wr_ptr] = v;
    wr_ptr = wr_ptr + 1'b1;
    len_left = len_left - 1'b1;
    expected_q.push_back(decoded_t'{v, end_of_run || (len_left == 0), len_left == 0});
  endtask

  // Runs one accepted compressed byte through the decoder mirror.
  task automatic decode_beat(input logic [BYTE_W-1:0] b, input logic st,
                             output int n, output bit used);
    logic [15:0]       tok;
    int                cnt;
    logic [DIST_W-1:0] rd;
    logic [BYTE_W-1:0] v;
    n = 0;
    if (st) begin
      flag_reg = '0;
      flag_cnt = '0;
      await_low = 1'b0;
      hi_byte = '0;
      len_left = len_cfg;
    end
    used = (len_left != 0);
    if (used) begin
      if (await_low) begin
        // Second match byte: copy from distance + 1 back, overlap allowed.
        tok = {hi_byte, b};
        cnt = int'(tok[15:12]) + int'(LEN_BIAS);
        rd = wr_ptr - tok[DIST_W-1:0] - 1'b1;
        await_low = 1'b0;
        for (int i = 0; i < cnt && len_left != 0; i++) begin
          v = hist_mem[rd];
          rd = rd + 1'b1;
          put_history(v, i == cnt - 1);
          n++;
        end
        flag_reg = flag_reg << 1;
        flag_cnt = flag_cnt - 1'b1;
      end else if (flag_cnt == 0) begin
        flag_reg = b;
        flag_cnt = FLAG_COUNT;
      end else if (flag_reg[7]) begin
        hi_byte = b;
        await_low = 1'b1;
      end else begin
        put_history(b, 1'b1);
        n = 1;
        flag_reg = flag_reg << 1;
        flag_cnt = flag_cnt - 1'b1;
      end
    end
  endtask

  // Compares output beats and predicts on every accepted input beat.
  always @(posedge clk) begin : scoreboard
    decoded_t  want;
    stim_row_t row;
    int        n;
    bit        used;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          log_mismatch($sformatf("unexpected output beat %02h", out_ch.out_byte));
        end else begin
          want = expected_q.pop_front();
          if (out_ch.out_byte !== want.data)
            log_mismatch($sformatf("out_byte %02h, expected %02h",
                                   out_ch.out_byte, want.data));
          if (out_ch.run_last !== want.last)
            log_mismatch($sformatf("run_last %b, expected %b on byte %02h",
                                   out_ch.run_last, want.last, want.data));
          if (out_ch.stream_done !== want.done)
            log_mismatch($sformatf("stream_done %b, expected %b on byte %02h",
                                   out_ch.stream_done, want.done, want.data));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        row = (beat_checks.size() != 0) ? beat_checks.pop_front() : NO_CHECK;
        decode_beat(in_ch.in_byte, in_ch.stream_start, n, used);
        if (used) used_items++;
        // Directed rows also carry the result worked out by hand.
        if (row.chk) begin
          if (n != int'(row.n))
            log_mismatch($sformatf("input %02h gives %0d bytes, table says %0d",
                                   row.data, n, row.n));
          else if (n > 0 && (expected_q[$].data !== row.last_byte ||
                             expected_q[$].done !== row.done))
            log_mismatch($sformatf("input %02h ends on %02h/%b, table says %02h/%b",
                                   row.data, expected_q[$].data, expected_q[$].done,
                                   row.last_byte, row.done));
        end
      end
    end
  end

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side back-pressure.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= calm || ($urandom_range(99) >= 24);
    end
  end

  // Drives one compressed byte, with a random gap ahead of it unless calm is set.
  task automatic send_beat(input logic [BYTE_W-1:0] data, input logic start,
                           input stim_row_t chk_row);
    while (!calm && $urandom_range(99) < 24) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    beat_checks.push_back(chk_row);
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= data;
    in_ch.stream_start <= start;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Waits until every expected byte is out and the copy engine has settled.
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_access(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [CFG_DATA_W-1:0] wdata,
                            output logic [CFG_DATA_W-1:0] rdata);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= addr;
    cfg_pwdata <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Writes the stream length while idle and reads it back.
  task automatic set_output_length(input logic [REM_W-1:0] len_value);
    logic [CFG_DATA_W-1:0] rdata;
    quiesce();
    cfg_access(1'b1, LEN_ADDR, CFG_DATA_W'(len_value), rdata);
    len_cfg = len_value;
    @(posedge clk);
    cfg_access(1'b0, LEN_ADDR, '0, rdata);
    if (rdata !== CFG_DATA_W'(len_value))
      log_mismatch($sformatf("output_length reads %h, wrote %h", rdata, len_value));
  endtask

  initial begin : stimulus
    logic [BYTE_W-1:0] flag;
    logic [3:0]        lf;
    logic [DIST_W-1:0] offs;
    int  pick;
    int  stream_len;
    int  produced;
    int  tokens;
    int  base;
    int  phase;
    bit  first;

    // Decoder mirror after reset.
    foreach (hist_mem[i]) hist_mem[i] = '0;
    wr_ptr = '0;
    flag_reg = '0;
    flag_cnt = '0;
    await_low = 1'b0;
    hi_byte = '0;
    len_left = '0;
    len_cfg = '0;

    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.in_byte <= '0;
    in_ch.stream_start <= 1'b0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].set_len) set_output_length(dir_rows[i].len);
      send_beat(dir_rows[i].data, dir_rows[i].start, dir_rows[i]);
    end

    // Random streams: mostly well-formed, with restarts and junk mixed in.
    base = used_items;
    phase = 0;
    while (used_items - base < RANDOM_ITEMS) begin
      pick = $urandom_range(9);
      case (pick)
        0: stream_len = 1;
        1: stream_len = 0;
        2: stream_len = 24'hFFFFFF;
        3: stream_len = 24'h800000;
        default: stream_len = $urandom_range(80, 2);
      endcase
      set_output_length(stream_len[REM_W-1:0]);
      calm = (phase >= 3 && phase <= 5);

      if (pick == 9 || stream_len == 0) begin
        send_beat(BYTE_W'($urandom_range(255)), 1'b1, NO_CHECK);
        repeat (12) send_beat(BYTE_W'($urandom_range(255)), $urandom_range(15) == 0,
                              NO_CHECK);
      end else begin
        produced = 0;
        tokens = 0;
        first = 1'b1;
        while (produced < stream_len && tokens < 48) begin
          flag = BYTE_W'($urandom_range(255));
          send_beat(flag, first, NO_CHECK);
          first = 1'b0;
          for (int k = 7; k >= 0 && produced < stream_len; k--) begin
            tokens++;
            if (flag[k]) begin
              lf = 4'($urandom_range(15));
              offs = DIST_W'(($urandom_range(3) == 0) ? $urandom_range(4095) :
                                                         $urandom_range(15));
              send_beat({lf, offs[11:8]}, 1'b0, NO_CHECK);
              // Now and then the stream restarts between the two match bytes.
              if ($urandom_range(39) == 0) begin
                first = 1'b1;
                produced = 0;
                break;
              end
              send_beat(offs[7:0], 1'b0, NO_CHECK);
              produced += int'(lf) + 3;
            end else begin
              send_beat(BYTE_W'($urandom_range(255)), 1'b0, NO_CHECK);
              produced++;
            end
          end
        end
      end

      // Trailing bytes after the stream has ended.
      repeat ($urandom_range(2)) send_beat(BYTE_W'($urandom_range(255)), 1'b0, NO_CHECK);
      phase++;
    end

    calm = 1'b0;
    quiesce();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
